/* design/skpr_pkg.sv */
// skpr_pkg: shared types, codes and helper functions for the serial keypad chain reader
// no dependencies; compile first
package skpr_pkg;

	localparam int KEYS_PER_PAD = 16;
	localparam int WORD_W       = 16;
	localparam int BITS_LEFT_W  = 12;
	localparam int SLOT_W       = 5;
	localparam int COUNT_W      = 5;
	localparam int INDEX_W      = 4;
	localparam logic [SLOT_W-1:0] MAX_SLOTS = SLOT_W'(16);

	// command codes
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_SHIFT = 1'b1;

	// status codes
	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_RANGE = 1'b1;

	// one job handed from the front to the back
	typedef struct packed {
		logic                  err;
		logic [WORD_W-1:0]     word;
		logic [SLOT_W-1:0]     slots;
	} skpr_job_t;

	// front to queue
	typedef struct packed {
		logic      valid;
		skpr_job_t job;
	} skpr_push_t;

	// queue to back
	typedef struct packed {
		logic      valid;
		skpr_job_t job;
	} skpr_head_t;

	// number of set bits in a word
	function automatic logic [COUNT_W-1:0] popcount16(input logic [WORD_W-1:0] w);
		logic [COUNT_W-1:0] c;
		c = '0;
		for (int i = 0; i < WORD_W; i++) begin
			c = c + COUNT_W'(w[i]);
		end
		return c;
	endfunction

	// index of the lowest set bit, 0 when none
	function automatic logic [INDEX_W-1:0] lowest_set(input logic [WORD_W-1:0] w);
		logic [INDEX_W-1:0] idx;
		idx = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (w[i]) begin
				idx = INDEX_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

/* design/skpr_cmd_if.sv */
// skpr_cmd_if: command channel (valid/ready plus command payload)
// depends on skpr_pkg
interface skpr_cmd_if;
	import skpr_pkg::*;

	logic       valid;
	logic       ready;
	logic       command;
	logic [7:0] keypad_number;
	logic [7:0] key_slots;
	logic       data_bit;

	modport source (output valid, command, keypad_number, key_slots, data_bit, input ready);
	modport sink   (input valid, command, keypad_number, key_slots, data_bit, output ready);
endinterface

/* design/skpr_res_if.sv */
// skpr_res_if: result channel (valid/ready plus result payload)
// depends on skpr_pkg
interface skpr_res_if;
	import skpr_pkg::*;

	logic               valid;
	logic               ready;
	logic               status;
	logic [WORD_W-1:0]  raw_keys;
	logic [COUNT_W-1:0] pressed_count;
	logic [INDEX_W-1:0] key_index;
	logic               key_valid;
	logic               last;

	modport source (output valid, status, raw_keys, pressed_count, key_index, key_valid, last,
		input ready);
	modport sink   (input valid, status, raw_keys, pressed_count, key_index, key_valid, last,
		output ready);
endinterface

/* design/skpr_cfg_if.sv */
// skpr_cfg_if: configuration write channel for keypad_count
// no dependencies
interface skpr_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

/* design/skpr_fifo.sv */
// skpr_fifo: short job queue between front and back
// depends on skpr_pkg
module skpr_fifo import skpr_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  skpr_push_t push,
	output logic       full,
	output skpr_head_t head,
	input  logic       pop
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	skpr_job_t     mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          empty;
	logic          do_push;
	logic          do_pop;

	// occupancy flags
	assign empty   = (count_q == '0);
	assign full    = (count_q == CW'(DEPTH));
	assign do_push = push.valid && !full;
	assign do_pop  = pop && !empty;

	assign head.valid = !empty;
	assign head.job   = mem_q[rd_ptr_q];

	// storage write
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.job;
		end
	end

	// pointers wrap at the last entry, occupancy count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10: begin
					count_q <= count_q + 1'b1;
				end
				2'b01: begin
					count_q <= count_q - 1'b1;
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push.valid)
		else $error("job pushed into a full queue");

endmodule

/* design/skpr_front.sv */
// skpr_front: accepts commands, runs the serial shift and queues error or burst jobs
// depends on skpr_pkg, skpr_cmd_if, skpr_cfg_if
module skpr_front import skpr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	skpr_cmd_if.sink   cmd,
	skpr_cfg_if.sink   cfg,
	input  logic       queue_full,
	output skpr_push_t push
);
	logic [7:0]             count_q;
	logic [WORD_W-1:0]      shift_word_q;
	logic [BITS_LEFT_W-1:0] bits_left_q;
	logic                   scan_active_q;
	logic [SLOT_W-1:0]      slots_wanted_q;

	logic                   accept;
	logic                   in_range;
	logic [SLOT_W-1:0]      slots_clamped;
	logic [WORD_W-1:0]      word_next;
	logic [BITS_LEFT_W-1:0] bits_next;
	logic                   shift_done;

	assign cfg.ready = 1'b1;
	assign cmd.ready = !queue_full;
	assign accept    = cmd.valid && cmd.ready;

	// classify the transaction
	assign in_range      = (cmd.keypad_number != 8'd0) && (cmd.keypad_number <= count_q);
	assign slots_clamped = (cmd.key_slots > 8'(MAX_SLOTS)) ? MAX_SLOTS
		: cmd.key_slots[SLOT_W-1:0];
	assign word_next     = {shift_word_q[WORD_W-2:0], cmd.data_bit};
	assign bits_next     = (bits_left_q != '0) ? bits_left_q - 1'b1 : bits_left_q;
	assign shift_done    = scan_active_q && (bits_next == '0);

	// job to the queue
	always_comb begin
		push.valid     = 1'b0;
		push.job.err   = 1'b0;
		push.job.word  = word_next;
		push.job.slots = (slots_wanted_q == '0) ? SLOT_W'(1) : slots_wanted_q;
		if (accept) begin
			unique case (cmd.command)
				CMD_START: begin
					if (!in_range) begin
						push.valid     = 1'b1;
						push.job.err   = 1'b1;
						push.job.word  = '0;
						push.job.slots = SLOT_W'(1);
					end
				end
				CMD_SHIFT: begin
					push.valid = shift_done;
				end
				default: begin
					push.valid = 1'b0;
				end
			endcase
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 8'd1;
		end else if (cfg.valid && cfg.ready) begin
			count_q <= cfg.data;
		end
	end

	// scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_word_q   <= '0;
			bits_left_q    <= '0;
			scan_active_q  <= 1'b0;
			slots_wanted_q <= '0;
		end else if (accept) begin
			unique case (cmd.command)
				CMD_START: begin
					if (in_range) begin
						bits_left_q    <= BITS_LEFT_W'(32'(cmd.keypad_number) * KEYS_PER_PAD);
						slots_wanted_q <= slots_clamped;
						scan_active_q  <= 1'b1;
					end else begin
						bits_left_q   <= '0;
						scan_active_q <= 1'b0;
					end
				end
				CMD_SHIFT: begin
					if (scan_active_q) begin
						shift_word_q <= word_next;
						bits_left_q  <= bits_next;
						if (bits_next == '0) begin
							scan_active_q <= 1'b0;
						end
					end
				end
				default: begin
					scan_active_q <= scan_active_q;
				end
			endcase
		end
	end

	a_active_has_bits: assert property (@(posedge clk) disable iff (!arst_n)
		scan_active_q |-> (bits_left_q != '0))
		else $error("scan active with no bits left");

	a_push_ends_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(push.valid && !push.job.err) |=> !scan_active_q)
		else $error("burst queued but scan still active");

endmodule

/* design/skpr_back.sv */
// skpr_back: drains jobs and emits one result per cycle into an output register
// while busy and not stalled by res.ready; depends on skpr_pkg, skpr_res_if
module skpr_back import skpr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  skpr_head_t head,
	output logic       pop,
	skpr_res_if.source res
);
	logic                busy_q;
	logic                err_q;
	logic [WORD_W-1:0]   word_q;
	logic [WORD_W-1:0]   mask_q;
	logic [COUNT_W-1:0]  count_q;
	logic [SLOT_W-1:0]   slots_left_q;
	logic                out_valid_q;

	logic                status_q;
	logic [WORD_W-1:0]   raw_q;
	logic [COUNT_W-1:0]  pcount_q;
	logic [INDEX_W-1:0]  index_q;
	logic                kvalid_q;
	logic                last_q;

	logic                can_emit;
	logic                found;
	logic [INDEX_W-1:0]  low_idx;

	assign pop      = !busy_q && head.valid;
	assign can_emit = busy_q && (!out_valid_q || res.ready);
	assign found    = (mask_q != '0);
	assign low_idx  = lowest_set(mask_q);

	assign res.valid         = out_valid_q;
	assign res.status        = status_q;
	assign res.raw_keys      = raw_q;
	assign res.pressed_count = pcount_q;
	assign res.key_index     = index_q;
	assign res.key_valid     = kvalid_q;
	assign res.last          = last_q;

	// job load and slot walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			slots_left_q <= '0;
		end else if (pop) begin
			busy_q       <= 1'b1;
			slots_left_q <= head.job.slots;
		end else if (can_emit) begin
			slots_left_q <= slots_left_q - 1'b1;
			if (slots_left_q == SLOT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// job payload
	always_ff @(posedge clk) begin
		if (pop) begin
			err_q   <= head.job.err;
			word_q  <= head.job.word;
			mask_q  <= head.job.word;
			count_q <= popcount16(head.job.word);
		end else if (can_emit && found) begin
			mask_q <= mask_q & ~(WORD_W'(1) << low_idx);
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (can_emit) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (can_emit) begin
			status_q <= err_q ? STATUS_RANGE : STATUS_OK;
			raw_q    <= word_q;
			pcount_q <= count_q;
			index_q  <= found ? low_idx : '0;
			kvalid_q <= found;
			last_q   <= (slots_left_q == SLOT_W'(1));
		end
	end

	a_busy_has_slots: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (slots_left_q != '0))
		else $error("busy with no slots left");

	a_error_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == STATUS_RANGE) |-> (last_q && !kvalid_q))
		else $error("error result not a single empty result");

endmodule

/* design/serial_keypad_chain_reader_unit.sv */
// serial_keypad_chain_reader_unit: top level of the serial keypad chain reader
// depends on skpr_pkg, the channel interfaces, skpr_front, skpr_fifo, skpr_back
//
//  channel | dir | handshake   | payload
//  --------+-----+-------------+-----------------------------------------------
//  cmd     | in  | valid/ready | command, keypad_number, key_slots, data_bit
//  res     | out | valid/ready | status, raw_keys, pressed_count, key_index,
//          |     |             | key_valid, last
//  cfg     | in  | valid/ready | data (keypad_count), always ready
//
// shift transactions are taken one per cycle while the job queue has room
// a queued job is loaded into the back end, which then emits its results
// (max(slots, 1) of them, at most 16; one for an error), paced by the output register
// cmd.ready drops only when the QUEUE_DEPTH job queue is full
// asynchronous active-low reset clears all control state; no clearing pass
module serial_keypad_chain_reader_unit import skpr_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	skpr_cmd_if.sink   cmd,
	skpr_cfg_if.sink   cfg,
	skpr_res_if.source res
);
	skpr_push_t push;
	skpr_head_t head;
	logic       queue_full;
	logic       pop;

	// command front end
	skpr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg        (cfg),
		.queue_full (queue_full),
		.push       (push)
	);

	// job queue
	skpr_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (queue_full),
		.head   (head),
		.pop    (pop)
	);

	// result back end
	skpr_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.res    (res)
	);

endmodule
